FILE: sv/mrr_pkg.sv
// Package: verdict codes for the Miller-Rabin round block.
package mrr_pkg;
  localparam logic [1:0] VERDICT_COMPOSITE   = 2'd0;
  localparam logic [1:0] VERDICT_PRIME       = 2'd1;
  localparam logic [1:0] VERDICT_BAD_WITNESS = 2'd2;
endpackage

FILE: sv/mrr_if.sv
// Interfaces: input item channel and result item channel.
interface mrr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] candidate;
  logic [31:0] witness;
  modport source (output valid, candidate, witness, input ready);
  modport sink (input valid, candidate, witness, output ready);
endinterface

interface mrr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

FILE: sv/mrr_front.sv
// Front end: accept items, settle trivial cases, queue work for the round engine.
module mrr_front #(
  parameter int NUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  mrr_in_if.sink               in_ch,
  output logic                 q_valid,
  input  logic                 q_ready,
  output logic                 q_direct,
  output logic [1:0]           q_verdict,
  output logic [NUM_WIDTH-1:0] q_n,
  output logic [NUM_WIDTH-1:0] q_a
);
  logic [NUM_WIDTH-1:0] n, a;
  logic                 direct;
  logic [1:0]           verdict;
  logic                 full;

  assign n = in_ch.candidate[NUM_WIDTH-1:0];
  assign a = in_ch.witness[NUM_WIDTH-1:0];

  always_comb begin
    direct  = 1'b1;
    verdict = mrr_pkg::VERDICT_COMPOSITE;
    if (n < NUM_WIDTH'(4)) begin
      verdict = (n >= NUM_WIDTH'(2)) ? mrr_pkg::VERDICT_PRIME : mrr_pkg::VERDICT_COMPOSITE;
    end else if (!n[0]) begin
      verdict = mrr_pkg::VERDICT_COMPOSITE;
    end else if (a < NUM_WIDTH'(2) || a > n - NUM_WIDTH'(2)) begin
      verdict = mrr_pkg::VERDICT_BAD_WITNESS;
    end else begin
      direct = 1'b0;
    end
  end

  // One-entry queue toward the back end.
  assign in_ch.ready = !full || q_ready;
  assign q_valid     = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      full <= 1'b1;
    end else if (q_ready) begin
      full <= 1'b0;
    end
    if (in_ch.valid && in_ch.ready) begin
      q_direct  <= direct;
      q_verdict <= verdict;
      q_n       <= n;
      q_a       <= a;
    end
  end
endmodule

FILE: sv/mrr_back.sv
// Back end: run one Miller-Rabin round with a shift-add modular multiplier.
module mrr_back #(
  parameter int NUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  logic                 q_direct,
  input  logic [1:0]           q_verdict,
  input  logic [NUM_WIDTH-1:0] q_n,
  input  logic [NUM_WIDTH-1:0] q_a,
  mrr_out_if.source            out_ch
);
  localparam int CW = $clog2(NUM_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SPLIT, S_POW_MUL, S_POW_SQ, S_CHECK, S_LOOP, S_DONE
  } state_t;

  state_t               state;
  logic [NUM_WIDTH-1:0] n, r, acc, sq;
  logic [CW-1:0]        s, j;
  logic [1:0]           verdict;

  // Multiplier: x*y mod n, one bit of y per cycle, MSB first.
  logic                 m_busy, m_start;
  logic [NUM_WIDTH-1:0] m_x, m_y, m_p;
  logic [CW-1:0]        m_cnt;
  logic [NUM_WIDTH:0]   m_dbl, m_sum;
  logic [NUM_WIDTH-1:0] m_d, m_next;

  always_comb begin
    m_dbl  = {m_p, 1'b0};
    m_d    = (m_dbl >= {1'b0, n}) ? NUM_WIDTH'(m_dbl - {1'b0, n}) : m_dbl[NUM_WIDTH-1:0];
    m_sum  = {1'b0, m_d} + (m_y[NUM_WIDTH-1] ? {1'b0, m_x} : '0);
    m_next = (m_sum >= {1'b0, n}) ? NUM_WIDTH'(m_sum - {1'b0, n}) : m_sum[NUM_WIDTH-1:0];
  end

  assign q_ready      = (state == S_IDLE);
  assign out_ch.valid = (state == S_DONE);
  assign out_ch.verdict = verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      m_busy  <= 1'b0;
      m_start <= 1'b0;
    end else begin
      if (m_busy) begin
        m_p   <= m_next;
        m_y   <= {m_y[NUM_WIDTH-2:0], 1'b0};
        m_cnt <= m_cnt - CW'(1);
        if (m_cnt == CW'(1)) m_busy <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            n <= q_n;
            verdict <= q_verdict;
            if (q_direct) begin
              state <= S_DONE;
            end else begin
              r <= q_n - NUM_WIDTH'(1);
              s <= '0;
              acc <= NUM_WIDTH'(1);
              sq <= q_a;
              state <= S_SPLIT;
            end
          end
        end
        S_SPLIT: begin
          if (!r[0]) begin
            r <= r >> 1;
            s <= s + CW'(1);
          end else begin
            state <= S_POW_MUL;
          end
        end
        S_POW_MUL: begin
          // Multiply acc by sq when the low exponent bit is set, else square sq.
          if (m_start) begin
            m_start <= 1'b0;
          end else if (!m_busy) begin
            if (r == '0) begin
              state <= S_CHECK;
            end else if (r[0]) begin
              m_x <= acc; m_y <= sq; m_p <= '0; m_cnt <= CW'(NUM_WIDTH);
              m_busy <= 1'b1; m_start <= 1'b1; state <= S_POW_SQ;
            end else begin
              m_x <= sq; m_y <= sq; m_p <= '0; m_cnt <= CW'(NUM_WIDTH);
              m_busy <= 1'b1; m_start <= 1'b1; state <= S_POW_SQ;
            end
          end
        end
        S_POW_SQ: begin
          // Clear the exponent bit after a multiply, shift it out after a square.
          if (m_start) begin
            m_start <= 1'b0;
          end else if (!m_busy) begin
            if (r[0]) begin
              acc <= m_p;
              r[0] <= 1'b0;
            end else begin
              sq <= m_p;
              r <= r >> 1;
            end
            state <= S_POW_MUL;
          end
        end
        S_CHECK: begin
          j <= CW'(1);
          if (acc == NUM_WIDTH'(1) || acc == n - NUM_WIDTH'(1)) begin
            verdict <= mrr_pkg::VERDICT_PRIME; state <= S_DONE;
          end else if (s <= CW'(1)) begin
            verdict <= mrr_pkg::VERDICT_COMPOSITE; state <= S_DONE;
          end else begin
            m_x <= acc; m_y <= acc; m_p <= '0; m_cnt <= CW'(NUM_WIDTH);
            m_busy <= 1'b1; m_start <= 1'b1; state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (m_start) begin
            m_start <= 1'b0;
          end else if (!m_busy) begin
            if (m_p == n - NUM_WIDTH'(1)) begin
              verdict <= mrr_pkg::VERDICT_PRIME; state <= S_DONE;
            end else if (m_p == NUM_WIDTH'(1) || j + CW'(1) >= s) begin
              verdict <= mrr_pkg::VERDICT_COMPOSITE; state <= S_DONE;
            end else begin
              j <= j + CW'(1);
              m_x <= m_p; m_y <= m_p; m_p <= '0; m_cnt <= CW'(NUM_WIDTH);
              m_busy <= 1'b1; m_start <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (out_ch.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_only_in_work: assert property (@(posedge clk) disable iff (rst)
    m_busy |-> (state == S_POW_SQ || state == S_LOOP))
    else $error("multiplier running outside a round");
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(verdict)))
    else $error("result dropped while stalled");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> (state != S_IDLE))
    else $error("queued item not taken");
`endif
endmodule

FILE: sv/miller_rabin_round_top.sv
// Top level of the Miller-Rabin round block.
//  channel | dir | payload                  | handshake
//  in_ch   | in  | candidate[31:0], witness | valid/ready
//  out_ch  | out | verdict[1:0]             | valid/ready
// Trivial items (small, even or bad witness) skip the round; their verdict passes the queue and S_DONE.
// A full round splits s factors of two out of n-1, then runs at most about 2*NUM_WIDTH
// multiplications on the bit-serial multiplier.
// Reset (rst, synchronous) empties the queue and idles the round engine.
// A one-item queue lets the front accept while the back computes or waits.
module miller_rabin_round_top #(
  parameter int NUM_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  mrr_in_if.sink    in_ch,
  mrr_out_if.source out_ch
);
  logic                 q_valid, q_ready, q_direct;
  logic [1:0]           q_verdict;
  logic [NUM_WIDTH-1:0] q_n, q_a;

  // Classify items and hold one for the engine.
  mrr_front #(.NUM_WIDTH(NUM_WIDTH)) u_front (
    .clk, .rst, .in_ch, .q_valid, .q_ready, .q_direct, .q_verdict, .q_n, .q_a
  );

  // Run the round and present the verdict.
  mrr_back #(.NUM_WIDTH(NUM_WIDTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_direct, .q_verdict, .q_n, .q_a, .out_ch
  );
endmodule
